/* rtl/core/ssmt_pkg.sv */
package ssmt_pkg;

   localparam int TABLE_CAPACITY = 1024;
   localparam int VALUE_BITS     = 32;
   localparam int INDEX_BITS     = 20;
   localparam int KEY_BITS       = 2 * INDEX_BITS;
   localparam int LIMIT_BITS     = INDEX_BITS + 1;
   localparam int ADDR_BITS      = $clog2(TABLE_CAPACITY);
   localparam int COUNT_BITS     = ADDR_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1) << INDEX_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_FULL  = COUNT_BITS'(TABLE_CAPACITY);

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_SPARE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_LIMIT = 2'd1;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

endpackage

/* rtl/core/sorted_sparse_matrix_table_core.sv */
// sequence: binary search over the sorted entries, then on insert every entry from the lower
//   bound up moves one slot; an index error goes straight to the result; the entry moves dominate
// throughput: one item at a time; the next request is taken once the result is registered
// the single entry memory (one read and one write per cycle) serves the search, moves and store
// reset: synchronous active high; clears entry count, limits to 1048576, empties the
//   result register; memory contents are left as they are
module sorted_sparse_matrix_table_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // row_index[19:0], column_index[39:20], write_value[71:40]
   input  logic [1:0]  req_tuser,   // action[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[31:0], was_present[32], zero[39:33]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ssmt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ssmt_pkg::LIMIT_BITS-1:0]     csr_data
);

   localparam int KB = ssmt_pkg::KEY_BITS;
   localparam int VB = ssmt_pkg::VALUE_BITS;
   localparam int IB = ssmt_pkg::INDEX_BITS;
   localparam int AB = ssmt_pkg::ADDR_BITS;
   localparam int CB = ssmt_pkg::COUNT_BITS;
   localparam int LB = ssmt_pkg::LIMIT_BITS;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_SRCH_RD   = 9'b000000010,
      S_SRCH_CMP  = 9'b000000100,
      S_PROBE_CHK = 9'b000001000,
      S_DECIDE    = 9'b000010000,
      S_SHIFT_RD  = 9'b000100000,
      S_SHIFT_WR  = 9'b001000000,
      S_STORE     = 9'b010000000,
      S_DONE      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // entry memory: keys sorted ascending, one read and one write port
   ssmt_pkg::entry_type mem [ssmt_pkg::TABLE_CAPACITY];
   ssmt_pkg::entry_type rd_data_ff;
   logic [AB-1:0]       rd_addr;
   logic                wr_en;
   logic [AB-1:0]       wr_addr;
   ssmt_pkg::entry_type wr_data;

   logic [LB-1:0] row_limit_ff, column_limit_ff;
   logic [CB-1:0] count_ff, count_in;

   // item being worked on
   ssmt_pkg::action_type act_ff, act_in;
   logic [KB-1:0]        key_ff, key_in;
   logic [VB-1:0]        wval_ff, wval_in;
   logic [CB-1:0]        lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [CB-1:0]        sh_ff, sh_in;
   logic                 present_ff, present_in;
   logic [VB-1:0]        old_ff, old_in;
   logic [VB-1:0]        res_value_ff, res_value_in;
   ssmt_pkg::status_type res_status_ff, res_status_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0]        rsp_value_ff, rsp_value_in;
   logic                 rsp_present_ff, rsp_present_in;
   ssmt_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [IB-1:0] req_row, req_col;
   logic [VB-1:0] new_value;

   assign req_row    = req_tdata[IB-1:0];
   assign req_col    = req_tdata[2*IB-1:IB];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_present_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign mid = CB'((CB + 1)'(lo_ff) + (CB + 1)'(hi_ff) >> 1);

   // value left at the position by a read or write
   assign new_value = (act_ff == ssmt_pkg::ACT_WRITE) ? wval_ff :
                      (present_ff ? old_ff : '0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_limit_ff    <= ssmt_pkg::LIMIT_RESET;
         column_limit_ff <= ssmt_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == ssmt_pkg::CSR_ROW_LIMIT) begin
            row_limit_ff <= csr_data;
         end
         if (csr_index == ssmt_pkg::CSR_COLUMN_LIMIT) begin
            column_limit_ff <= csr_data;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      act_in         = act_ff;
      key_in         = key_ff;
      wval_in        = wval_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      sh_in          = sh_ff;
      present_in     = present_ff;
      old_in         = old_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;
      rd_addr        = mid[AB-1:0];
      wr_en          = 1'b0;
      wr_addr        = sh_ff[AB-1:0];
      wr_data        = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in  = ssmt_pkg::action_type'(req_tuser);
               key_in  = {req_row, req_col};
               wval_in = req_tdata[2*IB+VB-1:2*IB];
               lo_in   = '0;
               hi_in   = count_ff;
               if ({1'b0, req_row} >= row_limit_ff || {1'b0, req_col} >= column_limit_ff) begin
                  present_in    = 1'b0;
                  res_value_in  = '0;
                  res_status_in = ssmt_pkg::ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[AB-1:0];
               state_in = S_SRCH_CMP;
            end else if (lo_ff < count_ff) begin
               // lower bound found, read it back to check the key
               rd_addr  = lo_ff[AB-1:0];
               state_in = S_PROBE_CHK;
            end else begin
               present_in = 1'b0;
               state_in   = S_DECIDE;
            end
         end
         S_SRCH_CMP: begin
            if (rd_data_ff.key < key_ff) begin
               lo_in = mid + CB'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SRCH_RD;
         end
         S_PROBE_CHK: begin
            present_in = (rd_data_ff.key == key_ff);
            old_in     = rd_data_ff.value;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            res_status_in = ssmt_pkg::ST_OK;
            res_value_in  = '0;
            sh_in         = count_ff;
            case (act_ff) inside
               ssmt_pkg::ACT_QUERY, ssmt_pkg::ACT_SPARE: begin
                  state_in = S_DONE;
               end
               default: begin
                  if (!present_ff && count_ff == ssmt_pkg::COUNT_FULL) begin
                     res_status_in = ssmt_pkg::ST_FULL;
                     state_in      = S_DONE;
                  end else if (!present_ff && count_ff > lo_ff) begin
                     state_in = S_SHIFT_RD;
                  end else begin
                     state_in = S_STORE;
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            rd_addr  = AB'(sh_ff - CB'(1));
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move one entry up to open the slot at the lower bound
            wr_en   = 1'b1;
            wr_addr = sh_ff[AB-1:0];
            wr_data = rd_data_ff;
            sh_in   = sh_ff - CB'(1);
            state_in = (sh_ff - CB'(1) > lo_ff) ? S_SHIFT_RD : S_STORE;
         end
         S_STORE: begin
            wr_en         = 1'b1;
            wr_addr       = lo_ff[AB-1:0];
            wr_data.key   = key_ff;
            wr_data.value = new_value;
            if (!present_ff) begin
               count_in = count_ff + CB'(1);
            end
            res_value_in  = new_value;
            res_status_in = ssmt_pkg::ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = res_value_ff;
               rsp_present_in = present_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff         <= act_in;
      key_ff         <= key_in;
      wval_ff        <= wval_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      sh_ff          <= sh_in;
      present_ff     <= present_in;
      old_ff         <= old_in;
      res_value_ff   <= res_value_in;
      res_status_ff  <= res_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
   end

endmodule
